// ===== design/priority_queue_dispatch_tracker_top_assert.svh =====
// Assertion macros for the priority queue dispatch tracker.
// Used by the top level only; set NO_ASSERTIONS to compile them out.
`ifndef PRIORITY_QUEUE_DISPATCH_TRACKER_TOP_ASSERT_SVH
`define PRIORITY_QUEUE_DISPATCH_TRACKER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PQDT_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define PQDT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PQDT_ASSERT_CLK(label, clk, rstn, prop)
`define PQDT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== design/pqdt_pkg.sv =====
// Package for the priority queue dispatch tracker.
// Holds depths, command and status codes and the sequencer state type.
`timescale 1ns / 1ps
`default_nettype none
package pqdt_pkg;
    localparam int FIFO_DEPTH_DEF     = 16;
    localparam int INFLIGHT_DEPTH_DEF = 16;
    localparam int NUM_CLASSES        = 3;

    localparam logic [1:0] CMD_PLACE    = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_COMPLETE = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WRITE,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== design/priority_queue_dispatch_tracker_top.sv =====
// Top level of the priority queue dispatch tracker.
// Depends on pqdt_pkg and priority_queue_dispatch_tracker_top_assert.svh.
//
// Usage: one item enters on the s_ channel (tdata = cmd, req_class, req_id,
// payload_handle) and exactly one result item leaves on the m_ channel.
// Place and clear go from accept through the write state to their result.
// Dispatch and complete walk the in-flight table one slot per cycle through
// a single compare unit, then pass through the read and write states before
// their result appears. The class FIFOs sit in one memory with a registered
// read port, which is read in the read state. s_tready is low from accept
// until the result is taken and rises in the next cycle; no new item is
// accepted before then. A stalled receiver holds the result in m_tdata and
// the block waits. Reset empties all classes, invalidates the in-flight
// table, sets the next id to one and the done count to zero; there is no
// clearing pass. The FIFO memory holds no reset value; only written
// entries reach the output.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_queue_dispatch_tracker_top_assert.svh"
module priority_queue_dispatch_tracker_top #(
    parameter int FIFO_DEPTH     = pqdt_pkg::FIFO_DEPTH_DEF,
    parameter int INFLIGHT_DEPTH = pqdt_pkg::INFLIGHT_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[1:0], req_class[3:2], req_id[19:4], payload_handle[35:20], zeros
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], out_id[17:2], out_class[19:18], out_payload[35:20],
    // position[40:36], zeros
    output logic [47:0]      m_tdata
);
    localparam int FW  = $clog2(FIFO_DEPTH);
    localparam int CW  = $clog2(FIFO_DEPTH + 1);
    localparam int IW  = $clog2(INFLIGHT_DEPTH);
    localparam int ICW = $clog2(INFLIGHT_DEPTH + 1);
    localparam int MD  = pqdt_pkg::NUM_CLASSES * FIFO_DEPTH;
    localparam int MW  = $clog2(MD);

    pqdt_pkg::state_t state_reg, state_next;

    logic [1:0]  cmd_reg, cls_reg;
    logic [15:0] rid_reg, pay_reg;
    logic [FW-1:0] head_reg [pqdt_pkg::NUM_CLASSES];
    logic [CW-1:0] cnt_reg  [pqdt_pkg::NUM_CLASSES];
    logic [INFLIGHT_DEPTH-1:0] ivalid_reg;
    logic [15:0] iid_reg  [INFLIGHT_DEPTH];
    logic [15:0] ipay_reg [INFLIGHT_DEPTH];
    logic [1:0]  icls_reg [INFLIGHT_DEPTH];
    logic [15:0] next_id_reg, done_reg;
    logic [ICW-1:0] idx_reg;
    logic        hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [1:0]  dcls_reg;
    logic [31:0] mem [MD];
    logic [31:0] rd_reg;
    logic [47:0] out_reg;
    logic        mvalid_reg;

    logic [1:0] in_cls;
    assign in_cls = (s_tdata[3:2] == 2'd3) ? 2'd2 : s_tdata[3:2];

    assign s_tready = (state_reg == pqdt_pkg::S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;

    // Shared compare unit for the table walk.
    logic [IW-1:0] idx_lo;
    logic          cmp_hit;
    assign idx_lo  = idx_reg[IW-1:0];
    assign cmp_hit = (cmd_reg == pqdt_pkg::CMD_DISPATCH) ? !ivalid_reg[idx_lo]
                   : (ivalid_reg[idx_lo] && iid_reg[idx_lo] == rid_reg);

    logic any_pending;
    assign any_pending = (cnt_reg[0] != '0) || (cnt_reg[1] != '0) || (cnt_reg[2] != '0);

    function automatic logic [FW-1:0] wrap_add(input logic [FW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-FW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(FIFO_DEPTH)) s = s - (CW+1)'(FIFO_DEPTH);
        return s[FW-1:0];
    endfunction

    function automatic logic [MW-1:0] maddr(input logic [1:0] c, input logic [FW-1:0] p);
        return MW'(c) * MW'(FIFO_DEPTH) + MW'(p);
    endfunction

    function automatic logic [47:0] pack(input logic [1:0] st, input logic [15:0] id,
            input logic [1:0] c, input logic [15:0] py, input logic [4:0] ps);
        return {7'd0, ps, py, c, id, st};
    endfunction

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pqdt_pkg::S_IDLE:  if (s_tvalid) begin
                state_next = (s_tdata[1:0] == pqdt_pkg::CMD_DISPATCH ||
                              s_tdata[1:0] == pqdt_pkg::CMD_COMPLETE)
                             ? pqdt_pkg::S_SCAN : pqdt_pkg::S_WRITE;
            end
            pqdt_pkg::S_SCAN:  if (idx_reg == ICW'(INFLIGHT_DEPTH - 1) || cmp_hit) begin
                state_next = pqdt_pkg::S_READ;
            end
            pqdt_pkg::S_READ:  state_next = pqdt_pkg::S_WRITE;
            pqdt_pkg::S_WRITE: state_next = pqdt_pkg::S_OUT;
            pqdt_pkg::S_OUT:   if (m_tready) begin
                state_next = pqdt_pkg::S_IDLE;
            end
            default:           state_next = pqdt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pqdt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pqdt_pkg::S_IDLE && s_tvalid) begin
            cmd_reg <= s_tdata[1:0];
            cls_reg <= in_cls;
            rid_reg <= s_tdata[19:4];
            pay_reg <= s_tdata[35:20];
            idx_reg <= '0;
            hit_reg <= 1'b0;
            dcls_reg <= (cnt_reg[0] != '0) ? 2'd0 : (cnt_reg[1] != '0) ? 2'd1 : 2'd2;
        end else if (state_reg == pqdt_pkg::S_SCAN) begin
            if (cmp_hit) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_lo;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (state_reg == pqdt_pkg::S_READ) begin
            rd_reg <= mem[maddr(dcls_reg, head_reg[dcls_reg])];
        end
        if (state_reg == pqdt_pkg::S_WRITE && cmd_reg == pqdt_pkg::CMD_PLACE &&
                cnt_reg[cls_reg] != CW'(FIFO_DEPTH)) begin
            mem[maddr(cls_reg, wrap_add(head_reg[cls_reg], cnt_reg[cls_reg]))] <=
                {next_id_reg, pay_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < pqdt_pkg::NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            ivalid_reg  <= '0;
            next_id_reg <= 16'd1;
            done_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            if (state_reg == pqdt_pkg::S_WRITE) begin
                mvalid_reg <= 1'b1;
                case (cmd_reg)
                    pqdt_pkg::CMD_PLACE: begin
                        if (cnt_reg[cls_reg] == CW'(FIFO_DEPTH)) begin
                            out_reg <= pack(pqdt_pkg::ST_FULL, '0, '0, '0, '0);
                        end else begin
                            cnt_reg[cls_reg] <= cnt_reg[cls_reg] + 1'b1;
                            out_reg <= pack(pqdt_pkg::ST_OK, next_id_reg, cls_reg, '0,
                                            5'(cnt_reg[cls_reg] + 1'b1));
                            next_id_reg <= (next_id_reg == 16'hFFFF) ? 16'd1
                                                                     : next_id_reg + 16'd1;
                        end
                    end
                    pqdt_pkg::CMD_DISPATCH: begin
                        if (!any_pending) begin
                            out_reg <= pack(pqdt_pkg::ST_EMPTY, '0, '0, '0, '0);
                        end else if (!hit_reg) begin
                            out_reg <= pack(pqdt_pkg::ST_FULL, '0, '0, '0, '0);
                        end else begin
                            ivalid_reg[hit_idx_reg] <= 1'b1;
                            iid_reg[hit_idx_reg]    <= rd_reg[31:16];
                            ipay_reg[hit_idx_reg]   <= rd_reg[15:0];
                            icls_reg[hit_idx_reg]   <= dcls_reg;
                            head_reg[dcls_reg] <= wrap_add(head_reg[dcls_reg], CW'(1));
                            cnt_reg[dcls_reg]  <= cnt_reg[dcls_reg] - 1'b1;
                            out_reg <= pack(pqdt_pkg::ST_OK, rd_reg[31:16], dcls_reg,
                                            rd_reg[15:0], '0);
                        end
                    end
                    pqdt_pkg::CMD_COMPLETE: begin
                        if (!hit_reg) begin
                            out_reg <= pack(pqdt_pkg::ST_NOTFOUND, rid_reg, '0, '0, '0);
                        end else begin
                            ivalid_reg[hit_idx_reg] <= 1'b0;
                            if (done_reg != 16'hFFFF) done_reg <= done_reg + 16'd1;
                            out_reg <= pack(pqdt_pkg::ST_OK, rid_reg, icls_reg[hit_idx_reg],
                                            ipay_reg[hit_idx_reg], '0);
                        end
                    end
                    default: begin
                        done_reg <= '0;
                        out_reg  <= pack(pqdt_pkg::ST_OK, '0, '0, '0, '0);
                    end
                endcase
            end else if (mvalid_reg && m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    `PQDT_ASSERT_CLK(a_valid_in_out, aclk, aresetn,
        (m_tvalid == (state_reg == pqdt_pkg::S_OUT)))
    `PQDT_ASSERT_CLK(a_id_nonzero, aclk, aresetn, (next_id_reg != 16'd0))
    `PQDT_ASSERT_CLK(a_no_accept_busy, aclk, aresetn, (m_tvalid |-> !s_tready))
endmodule
`default_nettype wire
